### rtl/core/multi_stack_shared_array_core_macros.svh
// Assertion macros shared by the core RTL.
`ifndef MULTI_STACK_SHARED_ARRAY_CORE_MACROS_SVH
`define MULTI_STACK_SHARED_ARRAY_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define MSSA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define MSSA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define MSSA_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define MSSA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### rtl/core/mssa_pkg.sv
package mssa_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int MODE_WIDTH = 2;
   localparam int SEL_WIDTH = 2;
   localparam int STATUS_WIDTH = 2;
   localparam int DEPTH_REG_WIDTH = 5;
   localparam logic [DEPTH_REG_WIDTH-1:0] DEPTH_RESET = 5'd16;

   localparam logic [MODE_WIDTH-1:0] MODE_PUSH = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_POP = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_LOOK = 2'd2;

   localparam logic [STATUS_WIDTH-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_OVERFLOW = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_UNDERFLOW = 2'd2;

   localparam logic signed [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic [MODE_WIDTH-1:0]        mode;
      logic [SEL_WIDTH-1:0]         stack_sel;
      logic signed [DATA_WIDTH-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] read_value;
      logic                         is_empty;
      logic [STATUS_WIDTH-1:0]      status;
   } rsp_type;

   // Decision for one operation, handed from the pointer logic to the memory side.
   typedef struct packed {
      logic                    mem_we;
      logic                    mem_re;
      logic                    is_empty;
      logic [STATUS_WIDTH-1:0] status;
   } op_type;

endpackage

### rtl/core/mssa_ctrl.sv
module mssa_ctrl
   import mssa_pkg::*;
#(
   parameter int NUM_STACKS = 4,
   parameter int MAX_DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      accept,
   input  req_type                                   req,
   input  logic [DEPTH_REG_WIDTH-1:0]                depth,
   output op_type                                    op,
   output logic [$clog2(NUM_STACKS*MAX_DEPTH)-1:0]  addr
);

   localparam int AW = $clog2(NUM_STACKS*MAX_DEPTH);
   localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam int CW = $clog2(MAX_DEPTH+1);
   localparam int LW = (CW > DEPTH_REG_WIDTH) ? CW : DEPTH_REG_WIDTH;
   localparam int XW = 8;

   logic [CW-1:0] fill_ff [NUM_STACKS];
   logic [CW-1:0] fill_in;
   logic [XW-1:0] sel_ext;
   logic [SW-1:0] idx;
   logic [CW-1:0] n;
   logic [LW-1:0] limit;
   logic [CW-1:0] slot;

   // The select is narrower than twice any legal stack count, so one subtract wraps it.
   always_comb begin
      sel_ext = XW'(req.stack_sel);
      if (sel_ext >= XW'(NUM_STACKS)) begin
         sel_ext = sel_ext - XW'(NUM_STACKS);
      end
      idx = SW'(sel_ext);
      n = fill_ff[idx];
      limit = (LW'(depth) > LW'(MAX_DEPTH)) ? LW'(MAX_DEPTH) : LW'(depth);
   end

   always_comb begin
      op = '0;
      fill_in = n;
      slot = n;
      case (req.mode)
         MODE_PUSH: begin
            if (LW'(n) >= limit) begin
               op.status = ST_OVERFLOW;
            end else begin
               op.mem_we = accept;
               fill_in = n + CW'(1);
            end
         end
         default: begin
            slot = n - CW'(1);
            if (n == '0) begin
               op.status = ST_UNDERFLOW;
            end else begin
               op.mem_re = accept;
               if (req.mode == MODE_POP) begin
                  fill_in = n - CW'(1);
               end
            end
         end
      endcase
      op.is_empty = (fill_in == '0);
      addr = AW'(idx) * AW'(MAX_DEPTH) + AW'(slot);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_STACKS; i++) begin
            fill_ff[i] <= '0;
         end
      end else if (accept) begin
         fill_ff[idx] <= fill_in;
      end
   end

endmodule

### rtl/core/multi_stack_shared_array_core.sv
// Several LIFO stacks that share one synchronous memory, each stack owning a
// region of MAX_DEPTH words and a fill counter kept in flip-flops.
// The request channel (req_valid, req_stall, req_data) carries one operation per
// transfer: push a value, pop the top, or look at the top (mode three also looks).
// The response channel (rsp_valid, rsp_stall, rsp_data) returns exactly one result
// per request, in order: the value popped or seen, the empty flag after the
// operation, and a status of ok, overflow or underflow.
// A request taken at a clock edge has its result in the output register after
// that edge. Throughput is one operation per cycle unless the receiver stalls;
// each operation uses the single memory port at most once. When the receiver
// stalls, the result holds and req_stall rises, since the memory read register
// is part of the result. Reset empties every stack and sets the depth limit to
// 16, with no clearing pass. The user must write the depth register (csr_wr_en,
// csr_wr_data) only while no operation is in flight; the block does not enforce it.
`include "multi_stack_shared_array_core_macros.svh"

module multi_stack_shared_array_core
   import mssa_pkg::*;
#(
   parameter int NUM_STACKS = 4,
   parameter int MAX_DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_type                    rsp_data,
   input  logic                       csr_wr_en,
   input  logic [DEPTH_REG_WIDTH-1:0] csr_wr_data
);

   localparam int AW = $clog2(NUM_STACKS*MAX_DEPTH);
   localparam int WORDS = NUM_STACKS*MAX_DEPTH;

   logic [DEPTH_REG_WIDTH-1:0] depth_ff;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic                       accept;
   op_type                     op;
   logic [AW-1:0]              addr;

   // Result payload, loaded on each accepted transfer.
   logic                       use_mem_ff;
   logic                       is_empty_ff;
   logic [STATUS_WIDTH-1:0]    status_ff;
   logic [DATA_WIDTH-1:0]      mem_q_ff;

   logic [DATA_WIDTH-1:0]      entry_mem [WORDS];

   // A waiting result blocks new requests, because the memory read register
   // would otherwise be overwritten before it is taken.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept = req_valid && !req_stall;

   mssa_ctrl #(
      .NUM_STACKS(NUM_STACKS),
      .MAX_DEPTH (MAX_DEPTH)
   ) u_ctrl (
      .clock (clock),
      .reset (reset),
      .accept(accept),
      .req   (req_data),
      .depth (depth_ff),
      .op    (op),
      .addr  (addr)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= DEPTH_RESET;
      end else if (csr_wr_en) begin
         depth_ff <= csr_wr_data;
      end
   end

   // Fill counters advance at the accepting edge, so a pop right after a push
   // reads a word that the memory already holds: no forwarding is needed.
   always_ff @(posedge clock) begin
      if (op.mem_we) begin
         entry_mem[addr] <= req_data.push_value;
      end
      if (op.mem_re) begin
         mem_q_ff <= entry_mem[addr];
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         use_mem_ff  <= op.mem_re;
         is_empty_ff <= op.is_empty;
         status_ff   <= op.status;
      end
   end

   // A push answers zero and an underflow answers the most negative value.
   always_comb begin
      rsp_data.is_empty = is_empty_ff;
      rsp_data.status = status_ff;
      if (use_mem_ff) begin
         rsp_data.read_value = mem_q_ff;
      end else if (status_ff == ST_UNDERFLOW) begin
         rsp_data.read_value = MOST_NEG;
      end else begin
         rsp_data.read_value = '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `MSSA_ASSERT_NEXT(a_accept_gives_result, clock, reset, accept, rsp_valid)
   `MSSA_ASSERT_NOW(a_stall_blocks_req, clock, reset, rsp_valid && rsp_stall, req_stall)
   `MSSA_ASSERT_NOW(a_uf_empty, clock, reset, rsp_valid && status_ff == ST_UNDERFLOW, is_empty_ff)

endmodule
